FILE: rtl/ccpp_pkg.sv
// ----------------------------------------------------------------------------
// Constant pool parser package
// Result record, push bundle, tag codes and payload sizes shared by the
// parser core, the result queue and the top level.
// ----------------------------------------------------------------------------
package ccpp_pkg;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = QPTR_W + 1;
	localparam int MAX_PUSH = 3;

	typedef enum logic [1:0] {
		KIND_SLOT  = 2'd0,
		KIND_TEXT  = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	localparam logic [7:0] TAG_UTF8          = 8'd1;
	localparam logic [7:0] TAG_INTEGER       = 8'd3;
	localparam logic [7:0] TAG_FLOAT         = 8'd4;
	localparam logic [7:0] TAG_LONG          = 8'd5;
	localparam logic [7:0] TAG_DOUBLE        = 8'd6;
	localparam logic [7:0] TAG_CLASS         = 8'd7;
	localparam logic [7:0] TAG_STRING        = 8'd8;
	localparam logic [7:0] TAG_FIELDREF      = 8'd9;
	localparam logic [7:0] TAG_METHODREF     = 8'd10;
	localparam logic [7:0] TAG_IFMETHODREF   = 8'd11;
	localparam logic [7:0] TAG_NAMEANDTYPE   = 8'd12;
	localparam logic [7:0] TAG_METHODHANDLE  = 8'd15;
	localparam logic [7:0] TAG_METHODTYPE    = 8'd16;
	localparam logic [7:0] TAG_DYNAMIC       = 8'd17;
	localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] slot_index;
		logic [7:0]  entry_tag;
		logic [15:0] first_index;
		logic [15:0] second_index;
		logic [63:0] raw_value;
		logic [3:0]  raw_count;
		logic [15:0] text_length;
		logic [7:0]  text_byte;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_PUSH-1:0]    res;
	} push_t;

	// Payload length in bytes; zero marks an unknown tag.
	function automatic logic [3:0] payload_size(input logic [7:0] tag);
		logic [3:0] sz;
		case (tag) inside
			TAG_UTF8, TAG_CLASS, TAG_METHODTYPE, TAG_STRING: sz = 4'd2;
			TAG_METHODHANDLE: sz = 4'd3;
			TAG_METHODREF, TAG_FIELDREF, TAG_NAMEANDTYPE, TAG_INTEGER,
			TAG_IFMETHODREF, TAG_DYNAMIC, TAG_INVOKEDYNAMIC, TAG_FLOAT: sz = 4'd4;
			TAG_LONG, TAG_DOUBLE: sz = 4'd8;
			default: sz = 4'd0;
		endcase
		return sz;
	endfunction

endpackage

FILE: rtl/ccpp_parser.sv
// ----------------------------------------------------------------------------
// Constant pool parser core
// Registers one input beat, then decodes it against the parse state and
// hands up to three results to the result queue in the same cycle.
// ----------------------------------------------------------------------------
module ccpp_parser import ccpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic [15:0] pool_entries,
	input  logic        space_ok,
	output push_t       push
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TAG,
		PH_PAYLOAD,
		PH_TEXT,
		PH_DONE,
		PH_ERROR
	} phase_t;

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  data_s1;
	logic [15:0] entries_s1;

	phase_t      phase_q, phase_d;
	logic [15:0] cur_q, cur_d;
	logic [15:0] total_q, total_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] left_q, left_d;
	logic [63:0] shift_q, shift_d;
	logic [15:0] tlen_q, tlen_d;

	logic        proc;
	logic [63:0] nshift;
	logic [15:0] left_dec;
	logic [3:0]  sz;
	logic        emit_rec;
	result_t     rec;
	logic        fin;
	logic        fin_w2;
	logic [16:0] cur_p1;
	logic [16:0] next_slot;
	logic        emit_fill;
	logic        emit_end;
	logic [15:0] end_slot;
	logic [1:0]  idx;

	assign proc     = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;

	// Input stage: take a new beat whenever the held one is consumed or empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1    <= mode;
			data_s1    <= data_byte;
			entries_s1 <= pool_entries;
		end
	end

	assign nshift    = {shift_q[55:0], data_s1};
	assign left_dec  = left_q - 16'd1;
	assign sz        = payload_size(data_s1);
	assign cur_p1    = {1'b0, cur_q} + 17'd1;

	always_comb begin
		phase_d  = phase_q;
		cur_d    = cur_q;
		total_d  = total_q;
		tag_d    = tag_q;
		left_d   = left_q;
		shift_d  = shift_q;
		tlen_d   = tlen_q;
		emit_rec = 1'b0;
		rec      = '0;
		fin      = 1'b0;
		fin_w2   = 1'b0;
		emit_end = 1'b0;
		end_slot = total_q;
		if (proc) begin
			if (mode_s1) begin
				total_d  = entries_s1;
				cur_d    = 16'd1;
				tag_d    = '0;
				left_d   = '0;
				shift_d  = '0;
				tlen_d   = '0;
				end_slot = entries_s1;
				if (entries_s1 <= 16'd1) begin
					emit_end = 1'b1;
					phase_d  = PH_DONE;
				end else begin
					phase_d = PH_TAG;
				end
			end else begin
				case (phase_q)
					PH_TAG: begin
						if (sz == 4'd0) begin
							emit_rec       = 1'b1;
							rec.kind       = KIND_ERROR;
							rec.slot_index = cur_q;
							rec.entry_tag  = data_s1;
							phase_d        = PH_ERROR;
						end else begin
							tag_d   = data_s1;
							left_d  = {12'd0, sz};
							shift_d = '0;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						shift_d = nshift;
						left_d  = left_dec;
						if (left_dec == 16'd0) begin
							emit_rec       = 1'b1;
							rec.kind       = KIND_SLOT;
							rec.slot_index = cur_q;
							rec.entry_tag  = tag_q;
							case (tag_q) inside
								TAG_UTF8: begin
									rec.text_length = nshift[15:0];
									tlen_d          = nshift[15:0];
									if (nshift[15:0] == 16'd0) begin
										fin = 1'b1;
									end else begin
										left_d  = nshift[15:0];
										phase_d = PH_TEXT;
									end
								end
								TAG_METHODREF, TAG_FIELDREF, TAG_NAMEANDTYPE: begin
									rec.first_index  = nshift[31:16];
									rec.second_index = nshift[15:0];
									fin              = 1'b1;
								end
								TAG_CLASS: begin
									rec.first_index = nshift[15:0];
									fin             = 1'b1;
								end
								TAG_LONG, TAG_DOUBLE: begin
									rec.raw_value = nshift;
									rec.raw_count = payload_size(tag_q);
									fin           = 1'b1;
									fin_w2        = 1'b1;
								end
								default: begin
									rec.raw_value = nshift;
									rec.raw_count = payload_size(tag_q);
									fin           = 1'b1;
								end
							endcase
						end
					end
					PH_TEXT: begin
						emit_rec        = 1'b1;
						rec.kind        = KIND_TEXT;
						rec.slot_index  = cur_q;
						rec.entry_tag   = tag_q;
						rec.text_length = tlen_q;
						rec.text_byte   = data_s1;
						left_d          = left_dec;
						if (left_dec == 16'd0) begin
							fin = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// Close the slot: filler after a two-slot entry, pool end past the last.
		next_slot = {1'b0, cur_q} + (fin_w2 ? 17'd2 : 17'd1);
		emit_fill = fin && fin_w2 && (cur_p1 < {1'b0, total_q});
		if (fin) begin
			if (next_slot >= {1'b0, total_q}) begin
				emit_end = 1'b1;
				phase_d  = PH_DONE;
				cur_d    = total_q;
			end else begin
				cur_d   = next_slot[15:0];
				phase_d = PH_TAG;
			end
		end

		push = '0;
		idx  = 2'd0;
		if (emit_rec) begin
			push.res[idx] = rec;
			idx           = idx + 2'd1;
		end
		if (emit_fill) begin
			push.res[idx].kind       = KIND_SLOT;
			push.res[idx].slot_index = cur_p1[15:0];
			idx                      = idx + 2'd1;
		end
		if (emit_end) begin
			push.res[idx].kind       = KIND_END;
			push.res[idx].slot_index = end_slot;
			idx                      = idx + 2'd1;
		end
		if (idx != 2'd0) begin
			push.res[idx - 2'd1].last = 1'b1;
		end
		push.cnt = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q   <= '0;
			total_q <= '0;
			tag_q   <= '0;
			left_q  <= '0;
			shift_q <= '0;
			tlen_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			total_q <= total_d;
			tag_q   <= tag_d;
			left_q  <= left_d;
			shift_q <= shift_d;
			tlen_q  <= tlen_d;
		end
	end

	a_slot_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAG) |-> (cur_q < total_q))
		else $error("tag phase with slot outside the pool");

	a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !mode_s1 && (phase_q == PH_IDLE || phase_q == PH_DONE ||
			phase_q == PH_ERROR)) |-> (push.cnt == 2'd0))
		else $error("data beat produced results outside a pool");

	a_end_means_done: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit_end) |=> (phase_q == PH_DONE))
		else $error("pool end emitted without entering done");

endmodule

FILE: rtl/ccpp_res_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to three results per cycle from the
// parser core and presents one result per beat on the output channel.
// ----------------------------------------------------------------------------
module ccpp_res_queue import ccpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    space_ok,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t head
);

	result_t           mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign space_ok  = count_q <= QCNT_W'(QDEPTH - MAX_PUSH);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PUSH; i++) begin
			if (2'(i) < push.cnt) begin
				mem[wr_ptr_q + QPTR_W'(i)] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.cnt) - QCNT_W'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> space_ok)
		else $error("results pushed without room in the queue");

endmodule

FILE: rtl/class_constant_pool_parser_unit.sv
// ----------------------------------------------------------------------------
// Class constant pool parser unit
// Parses a class-file constant pool one byte per beat into slot records,
// text bytes, pool end and error results.
// ----------------------------------------------------------------------------
// A start beat (mode 1) loads the pool entry count; each following data beat
// carries one pool byte. The unit takes one input beat per cycle as long as
// its four-entry result queue holds at most one result; an accepted beat
// waits in the input register and is decoded as soon as the queue has room;
// its results (up to three: slot record, filler after Long or Double, pool
// end) can be taken from the cycle after that. Results leave at one per
// cycle while the output does not stall, so the output port sets the rate:
// a beat that yields k results can hold the input while the queue drains.
module class_constant_pool_parser_unit import ccpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic [15:0] pool_entries,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] slot_index,
	output logic [7:0]  entry_tag,
	output logic [15:0] first_index,
	output logic [15:0] second_index,
	output logic [63:0] raw_value,
	output logic [3:0]  raw_count,
	output logic [15:0] text_length,
	output logic [7:0]  text_byte,
	output logic        last
);

	push_t   push;
	logic    space_ok;
	result_t head;

	ccpp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.data_byte    (data_byte),
		.pool_entries (pool_entries),
		.space_ok     (space_ok),
		.push         (push)
	);

	ccpp_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind         = head.kind;
	assign slot_index   = head.slot_index;
	assign entry_tag    = head.entry_tag;
	assign first_index  = head.first_index;
	assign second_index = head.second_index;
	assign raw_value    = head.raw_value;
	assign raw_count    = head.raw_count;
	assign text_length  = head.text_length;
	assign text_byte    = head.text_byte;
	assign last         = head.last;

endmodule

FILE: tb/class_constant_pool_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant pool parser unit regression
// Feeds start and pool-byte beats into the parser under bursty input and a
// stalling output, tracks the expected slot, text, pool-end and error results
// with a behavioral parser model, and checks every output beat field by field.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_unit_test;
	import ccpp_pkg::*;

	localparam int RANDOM_ITEMS = 450;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TAG, PH_PAYLOAD, PH_TEXT, PH_DONE, PH_ERROR
	} parse_phase_t;

	typedef struct {
		logic        m;
		logic [7:0]  b;
		logic [15:0] n;
		bit          typed;
		result_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [7:0]  data_byte;
	logic [15:0] pool_entries;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [15:0] slot_index;
	logic [7:0]  entry_tag;
	logic [15:0] first_index;
	logic [15:0] second_index;
	logic [63:0] raw_value;
	logic [3:0]  raw_count;
	logic [15:0] text_length;
	logic [7:0]  text_byte;
	logic        last;

	// parser model state
	parse_phase_t ph        = PH_IDLE;
	logic [15:0]  cur_slot  = '0;
	logic [15:0]  slot_total = '0;
	logic [7:0]   tag_hold  = '0;
	logic [15:0]  remaining = '0;
	logic [63:0]  shift_reg = '0;
	logic [15:0]  utf_len   = '0;

	result_t beat_results[$];
	result_t pending_results[$];
	stim_row_t directed_rows[$];

	int mismatches = 0;
	int fed_items = 0;
	int burst_left = 0;
	int hold_request = 0;

	logic [7:0] valid_tags[15] = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE,
		TAG_CLASS, TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF,
		TAG_NAMEANDTYPE, TAG_METHODHANDLE, TAG_METHODTYPE, TAG_DYNAMIC, TAG_INVOKEDYNAMIC};

	class_constant_pool_parser_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .data_byte(data_byte), .pool_entries(pool_entries),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .slot_index(slot_index), .entry_tag(entry_tag),
		.first_index(first_index), .second_index(second_index),
		.raw_value(raw_value), .raw_count(raw_count),
		.text_length(text_length), .text_byte(text_byte), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic result_t mk_result(kind_t k, logic [15:0] slot, logic [7:0] tag,
		logic [15:0] f, logic [15:0] s, logic [63:0] raw, logic [3:0] cnt,
		logic [15:0] tlen, logic [7:0] tb, logic lst);
		result_t r;
		r.kind = k;
		r.slot_index = slot;
		r.entry_tag = tag;
		r.first_index = f;
		r.second_index = s;
		r.raw_value = raw;
		r.raw_count = cnt;
		r.text_length = tlen;
		r.text_byte = tb;
		r.last = lst;
		return r;
	endfunction

	function automatic logic [3:0] tag_payload_bytes(logic [7:0] tag);
		case (tag)
			TAG_UTF8, TAG_CLASS, TAG_METHODTYPE, TAG_STRING: return 4'd2;
			TAG_METHODHANDLE: return 4'd3;
			TAG_METHODREF, TAG_FIELDREF, TAG_NAMEANDTYPE, TAG_INTEGER, TAG_FLOAT,
			TAG_IFMETHODREF, TAG_DYNAMIC, TAG_INVOKEDYNAMIC: return 4'd4;
			TAG_LONG, TAG_DOUBLE: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	// Advance past a slot one or two wide; add the filler and pool end as due.
	function automatic void close_slot(int width);
		int nxt;
		nxt = int'(cur_slot) + width;
		if (width == 2 && int'(cur_slot) + 1 < int'(slot_total))
			beat_results.push_back(mk_result(KIND_SLOT, cur_slot + 16'd1, 8'h00,
				'0, '0, '0, '0, '0, '0, 1'b0));
		if (nxt >= int'(slot_total)) begin
			beat_results.push_back(mk_result(KIND_END, slot_total, 8'h00,
				'0, '0, '0, '0, '0, '0, 1'b0));
			ph = PH_DONE;
			cur_slot = slot_total;
		end else begin
			cur_slot = nxt[15:0];
			ph = PH_TAG;
		end
	endfunction

	function automatic void payload_complete();
		logic [15:0] hi;
		logic [15:0] lo;
		hi = shift_reg[31:16];
		lo = shift_reg[15:0];
		if (tag_hold == TAG_UTF8) begin
			utf_len = lo;
			beat_results.push_back(mk_result(KIND_SLOT, cur_slot, tag_hold,
				'0, '0, '0, '0, lo, '0, 1'b0));
			if (lo == 16'd0)
				close_slot(1);
			else begin
				remaining = lo;
				ph = PH_TEXT;
			end
		end else if (tag_hold == TAG_METHODREF || tag_hold == TAG_FIELDREF ||
			tag_hold == TAG_NAMEANDTYPE) begin
			beat_results.push_back(mk_result(KIND_SLOT, cur_slot, tag_hold,
				hi, lo, '0, '0, '0, '0, 1'b0));
			close_slot(1);
		end else if (tag_hold == TAG_CLASS) begin
			beat_results.push_back(mk_result(KIND_SLOT, cur_slot, tag_hold,
				lo, '0, '0, '0, '0, '0, 1'b0));
			close_slot(1);
		end else begin
			beat_results.push_back(mk_result(KIND_SLOT, cur_slot, tag_hold,
				'0, '0, shift_reg, tag_payload_bytes(tag_hold), '0, '0, 1'b0));
			close_slot((tag_hold == TAG_LONG || tag_hold == TAG_DOUBLE) ? 2 : 1);
		end
	endfunction

	// Apply one accepted beat to the model; fills beat_results, returns 1 if
	// the beat does any work.
	function automatic bit parse_beat(logic m, logic [7:0] b, logic [15:0] n);
		logic [3:0] sz;
		bit busy;
		beat_results.delete();
		busy = m || ph == PH_TAG || ph == PH_PAYLOAD || ph == PH_TEXT;
		if (m) begin
			tag_hold = '0;
			remaining = '0;
			shift_reg = '0;
			utf_len = '0;
			slot_total = n;
			cur_slot = 16'd1;
			if (n <= 16'd1) begin
				beat_results.push_back(mk_result(KIND_END, n, 8'h00,
					'0, '0, '0, '0, '0, '0, 1'b0));
				ph = PH_DONE;
			end else
				ph = PH_TAG;
		end else if (ph == PH_TAG) begin
			sz = tag_payload_bytes(b);
			if (sz == 4'd0) begin
				beat_results.push_back(mk_result(KIND_ERROR, cur_slot, b,
					'0, '0, '0, '0, '0, '0, 1'b0));
				ph = PH_ERROR;
			end else begin
				tag_hold = b;
				remaining = 16'(sz);
				shift_reg = '0;
				ph = PH_PAYLOAD;
			end
		end else if (ph == PH_PAYLOAD) begin
			shift_reg = {shift_reg[55:0], b};
			remaining = remaining - 16'd1;
			if (remaining == 16'd0)
				payload_complete();
		end else if (ph == PH_TEXT) begin
			beat_results.push_back(mk_result(KIND_TEXT, cur_slot, tag_hold,
				'0, '0, '0, '0, utf_len, b, 1'b0));
			remaining = remaining - 16'd1;
			if (remaining == 16'd0)
				close_slot(1);
		end
		if (beat_results.size() > 0)
			beat_results[beat_results.size() - 1].last = 1'b1;
		return busy;
	endfunction

	task automatic send_beat(input logic m, input logic [7:0] b, input logic [15:0] n,
		input bit typed, input result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= b;
		pool_entries <= n;
		do @(posedge clk); while (in_stall);
		if (parse_beat(m, b, n))
			fed_items++;
		if (typed)
			pending_results.push_back(want);
		else
			foreach (beat_results[i])
				pending_results.push_back(beat_results[i]);
	endtask

	task automatic send_data(input logic [7:0] b);
		send_beat(1'b0, b, 16'($urandom), 1'b0, '0);
	endtask

	task automatic send_start(input logic [15:0] n);
		send_beat(1'b1, 8'($urandom), n, 1'b0, '0);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// One pool: mostly well formed, with stray bytes and early restarts mixed in.
	task automatic send_pool();
		int r;
		int slot;
		int emitted;
		int len;
		int n_text;
		logic [15:0] count;
		logic [7:0] t;
		logic [3:0] sz;
		r = $urandom_range(0, 99);
		if (r < 4)
			count = 16'($urandom);
		else if (r < 9)
			count = 16'($urandom_range(0, 1));
		else
			count = 16'($urandom_range(2, 12));
		send_start(count);
		slot = 1;
		emitted = 0;
		while (slot < int'(count) && emitted < 14) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_data(8'($urandom));
			else if (r < 6)
				return;
			t = valid_tags[$urandom_range(0, 14)];
			send_data(t);
			if (t == TAG_UTF8) begin
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(0, 65535);
				else
					len = $urandom_range(0, 6);
				send_data(len[15:8]);
				send_data(len[7:0]);
				n_text = (len > 6) ? $urandom_range(0, 5) : len;
				repeat (n_text) send_data(rand_byte());
				// long text: drop the rest of this pool
				if (n_text != len)
					return;
			end else begin
				sz = tag_payload_bytes(t);
				repeat (sz) send_data(rand_byte());
			end
			slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
			emitted++;
		end
		if ($urandom_range(0, 4) == 0)
			send_data(8'($urandom));
	endtask

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%t: unexpected result: expected none, actual kind %0d slot %0d",
					$time, kind, slot_index);
			end else begin
				want = pending_results.pop_front();
				compare_field("kind", want.kind, kind);
				compare_field("slot_index", want.slot_index, slot_index);
				compare_field("entry_tag", want.entry_tag, entry_tag);
				compare_field("first_index", want.first_index, first_index);
				compare_field("second_index", want.second_index, second_index);
				compare_field("raw_value", want.raw_value, raw_value);
				compare_field("raw_count", want.raw_count, raw_count);
				compare_field("text_length", want.text_length, text_length);
				compare_field("text_byte", want.text_byte, text_byte);
				compare_field("last", want.last, last);
			end
		end
	end

	// Output side: stall styles change every so often; a hold request overrides.
	initial begin
		int style;
		int style_left;
		int hold_left;
		int tick;
		style = 0;
		style_left = 0;
		hold_left = 0;
		tick = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 3);
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 70);
					default: out_stall <= (tick % 3 == 0);
				endcase
		end
	end

	initial begin
		#10_000_000;
		$display("class_constant_pool_parser_unit regression: fail");
		$finish;
	end

	initial begin
		bit held_once;
		bit paused_once;
		held_once = 0;
		paused_once = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		data_byte = 8'h00;
		pool_entries = 16'h0000;

		directed_rows.push_back(stim_row_t'{1'b0, 8'h07, 16'h0000, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b1, 8'hFF, 16'h0000, 1'b1,
			mk_result(KIND_END, 16'd0, 8'h00, '0, '0, '0, '0, '0, '0, 1'b1)});
		directed_rows.push_back(stim_row_t'{1'b1, 8'h00, 16'h0001, 1'b1,
			mk_result(KIND_END, 16'd1, 8'h00, '0, '0, '0, '0, '0, '0, 1'b1)});
		directed_rows.push_back(stim_row_t'{1'b0, 8'h01, 16'h0000, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b1, 8'h00, 16'hFFFF, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, 8'h00, 16'h0000, 1'b1,
			mk_result(KIND_ERROR, 16'd1, 8'h00, '0, '0, '0, '0, '0, '0, 1'b1)});
		directed_rows.push_back(stim_row_t'{1'b0, TAG_CLASS, 16'h0000, 1'b0, '0});
		// Long in the last slot: record and pool end, no filler
		directed_rows.push_back(stim_row_t'{1'b1, 8'h00, 16'h0002, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, TAG_LONG, 16'h0000, 1'b0, '0});
		repeat (8) directed_rows.push_back(stim_row_t'{1'b0, 8'hFF, 16'hFFFF, 1'b0, '0});
		// restart in the middle of Utf8 text
		directed_rows.push_back(stim_row_t'{1'b1, 8'h00, 16'h0003, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, TAG_UTF8, 16'h0000, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, 8'h00, 16'h0000, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, 8'h01, 16'h0000, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b1, 8'h00, 16'h0003, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{1'b0, 8'hFF, 16'h0000, 1'b1,
			mk_result(KIND_ERROR, 16'd1, 8'hFF, '0, '0, '0, '0, '0, '0, 1'b1)});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_beat(directed_rows[i].m, directed_rows[i].b, directed_rows[i].n,
				directed_rows[i].typed, directed_rows[i].want);
		pause_until_drained();

		fed_items = 0;
		while (fed_items < RANDOM_ITEMS) begin
			// hold the output long enough for the input to back up
			if (!held_once && fed_items > 150) begin
				hold_request = 120;
				held_once = 1;
			end
			if (!paused_once && fed_items > 300) begin
				pause_until_drained();
				paused_once = 1;
			end
			send_pool();
		end

		pause_until_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("class_constant_pool_parser_unit regression: pass");
		else
			$display("class_constant_pool_parser_unit regression: fail");
		$finish;
	end

endmodule
